// ===== hw/rtl/vector2_rotate_macros.svh =====
// ----------------------------------------------------------------------------
// vector2_rotate_macros
// Assertion shorthands used by the vector rotation top level.
// ----------------------------------------------------------------------------
`ifndef VECTOR2_ROTATE_MACROS_SVH
`define VECTOR2_ROTATE_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define VROT_ASSERT_IMP(label, rst_n, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is asserted
`define VROT_ASSERT_NXT(label, rst_n, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also covers reset itself
`define VROT_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/vrot_pkg.sv =====
// ----------------------------------------------------------------------------
// vrot_pkg
// Constants, gain and arctangent helpers for the CORDIC vector rotator.
// ----------------------------------------------------------------------------
package vrot_pkg;

    localparam int STAGES_DEF     = 16;
    localparam int DATA_WIDTH_DEF = 16;
    localparam int TABLE_LEN      = 24;
    localparam int IN_W           = 16;
    localparam int OUT_W          = 17;
    localparam int Z_W            = 32;
    localparam int GAIN_W         = 31;
    localparam int GAIN_FRAC      = 30;
    localparam int INT_W          = 18;
    localparam int FOLD_W         = IN_W + 1;
    localparam int PROD_W         = FOLD_W + GAIN_W;

    localparam longint GAIN_BASE  = 64'd652032874;
    localparam longint GAIN_TAIL  = 64'd434688583;

    typedef logic signed [IN_W-1:0]  t_in;
    typedef logic signed [OUT_W-1:0] t_out;
    typedef logic signed [Z_W-1:0]   t_z;

    // Number of micro-rotations actually built
    function automatic int cell_count(input int stages);
        return (stages > TABLE_LEN) ? TABLE_LEN : stages;
    endfunction

    // Q30 gain compensation with first-order tail correction
    function automatic logic [GAIN_W-1:0] gain_q30(input int stages);
        longint sh;
        longint corr;
        sh   = 2 * cell_count(stages);
        corr = (GAIN_TAIL + (64'sd1 <<< (sh - 1))) >>> sh;
        return GAIN_W'(GAIN_BASE + corr);
    endfunction

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [Z_W-1:0] atan_turn(input int idx);
        logic [Z_W-1:0] v;
        case (idx)
            0:       v = 32'h2000_0000;
            1:       v = 32'h12E4_051E;
            2:       v = 32'h09FB_385B;
            3:       v = 32'h0511_11D4;
            4:       v = 32'h028B_0D43;
            5:       v = 32'h0145_D7E1;
            6:       v = 32'h00A2_F61E;
            7:       v = 32'h0051_7C55;
            8:       v = 32'h0028_BE53;
            9:       v = 32'h0014_5F2F;
            10:      v = 32'h000A_2F98;
            11:      v = 32'h0005_17CC;
            12:      v = 32'h0002_8BE6;
            13:      v = 32'h0001_45F3;
            14:      v = 32'h0000_A2FA;
            15:      v = 32'h0000_517D;
            16:      v = 32'h0000_28BE;
            17:      v = 32'h0000_145F;
            18:      v = 32'h0000_0A30;
            19:      v = 32'h0000_0518;
            20:      v = 32'h0000_028C;
            21:      v = 32'h0000_0146;
            22:      v = 32'h0000_00A3;
            23:      v = 32'h0000_0051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/vrot_prescale.sv =====
// ----------------------------------------------------------------------------
// vrot_prescale
// Folds the angle into +-pi/2, multiplies the vector by the CORDIC gain
// compensation and rescales it to the datapath format. Three register stages.
// ----------------------------------------------------------------------------
module vrot_prescale #(
    parameter int STAGES     = vrot_pkg::STAGES_DEF,
    parameter int DATA_WIDTH = vrot_pkg::DATA_WIDTH_DEF,
    parameter int W          = DATA_WIDTH + vrot_pkg::INT_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  vrot_pkg::t_in        i_x_in,
    input  vrot_pkg::t_in        i_y_in,
    input  vrot_pkg::t_in        i_angle,
    output logic                 o_valid,
    output logic signed [W-1:0]  o_x,
    output logic signed [W-1:0]  o_y,
    output vrot_pkg::t_z         o_z
);
    import vrot_pkg::*;

    localparam logic signed [GAIN_W-1:0] GAIN = $signed(gain_q30(STAGES));

    // Fold stage
    logic                     w_fold;
    logic signed [FOLD_W-1:0] w_fx, w_fy;
    logic        [IN_W-1:0]   w_fa;
    logic signed [FOLD_W-1:0] r_a_x, r_a_y;
    t_z                       r_a_z;
    logic                     r_a_valid;

    // Multiply stage
    logic signed [PROD_W-1:0] r_b_px, r_b_py;
    t_z                       r_b_z;
    logic                     r_b_valid;

    // Rescale stage
    logic signed [W-1:0]      w_cx, w_cy;
    logic signed [W-1:0]      r_c_x, r_c_y;
    t_z                       r_c_z;
    logic                     r_c_valid;

    // Outside +-pi/2 when the top two angle bits differ: negate and flip the sign bit
    assign w_fold = i_angle[IN_W-1] ^ i_angle[IN_W-2];
    assign w_fx   = w_fold ? -FOLD_W'(i_x_in) : FOLD_W'(i_x_in);
    assign w_fy   = w_fold ? -FOLD_W'(i_y_in) : FOLD_W'(i_y_in);
    assign w_fa   = {i_angle[IN_W-1] ^ w_fold, i_angle[IN_W-2:0]};

    // Hold the folded transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_x <= w_fx;
            r_a_y <= w_fy;
            r_a_z <= {w_fa, {(Z_W-IN_W){1'b0}}};
        end
    end

    // Apply the gain compensation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_px <= PROD_W'(r_a_x) * PROD_W'(GAIN);
            r_b_py <= PROD_W'(r_a_y) * PROD_W'(GAIN);
            r_b_z  <= r_a_z;
        end
    end

    // Rescale Q30 product to the datapath fraction width
    generate
        if (DATA_WIDTH >= GAIN_FRAC) begin : g_shift_up
            assign w_cx = W'(r_b_px) <<< (DATA_WIDTH - GAIN_FRAC);
            assign w_cy = W'(r_b_py) <<< (DATA_WIDTH - GAIN_FRAC);
        end else begin : g_round_down
            localparam int SH = GAIN_FRAC - DATA_WIDTH;
            localparam logic signed [PROD_W:0] HALF = (PROD_W+1)'(1) << (SH - 1);
            logic signed [PROD_W:0] w_rx, w_ry;
            assign w_rx = (PROD_W+1)'(r_b_px) + HALF;
            assign w_ry = (PROD_W+1)'(r_b_py) + HALF;
            assign w_cx = W'(w_rx >>> SH);
            assign w_cy = W'(w_ry >>> SH);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_x <= w_cx;
            r_c_y <= w_cy;
            r_c_z <= r_b_z;
        end
    end

    assign o_valid = r_c_valid;
    assign o_x     = r_c_x;
    assign o_y     = r_c_y;
    assign o_z     = r_c_z;

endmodule

// ===== hw/rtl/vrot_cell.sv =====
// ----------------------------------------------------------------------------
// vrot_cell
// One CORDIC micro-rotation by atan(2^-IDX), registered, handing the vector
// and the residual angle to the next cell.
// ----------------------------------------------------------------------------
module vrot_cell #(
    parameter int W   = vrot_pkg::DATA_WIDTH_DEF + vrot_pkg::INT_W,
    parameter int IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [W-1:0]  i_x,
    input  logic signed [W-1:0]  i_y,
    input  vrot_pkg::t_z         i_z,
    output logic                 o_valid,
    output logic signed [W-1:0]  o_x,
    output logic signed [W-1:0]  o_y,
    output vrot_pkg::t_z         o_z
);
    import vrot_pkg::*;

    localparam t_z ATAN = $signed(atan_turn(IDX));

    logic signed [W-1:0] w_dx, w_dy;
    logic                w_pos;
    logic                r_valid;
    logic signed [W-1:0] r_x, r_y;
    t_z                  r_z;

    // Shifted cross terms; a zero residual rotates positively
    assign w_dx  = i_y >>> IDX;
    assign w_dy  = i_x >>> IDX;
    assign w_pos = ~i_z[Z_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Advance one micro-rotation
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_pos) begin
                r_x <= i_x - w_dx;
                r_y <= i_y + w_dy;
                r_z <= i_z - ATAN;
            end else begin
                r_x <= i_x + w_dx;
                r_y <= i_y - w_dy;
                r_z <= i_z + ATAN;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

// ===== hw/rtl/vector2_rotate.sv =====
// ----------------------------------------------------------------------------
// vector2_rotate
// Rotates a signed 2D vector by a binary angle with a gain-corrected CORDIC.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle while not stalled and returns one rotated vector for each,
// rx = x*cos(a) - y*sin(a), ry = x*sin(a) + y*cos(a), rounded to nearest.
// The pipeline is three prescale stages (angle fold, gain multiply, rescale),
// one register per CORDIC cell (min(STAGES, 24) cells are built),
// and the rounding output register. The whole pipeline freezes while a
// result sits on the output and i_stall is high; o_stall follows that.
module vector2_rotate #(
    parameter int STAGES     = vrot_pkg::STAGES_DEF,
    parameter int DATA_WIDTH = vrot_pkg::DATA_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  vrot_pkg::t_in  i_x_in,
    input  vrot_pkg::t_in  i_y_in,
    input  vrot_pkg::t_in  i_angle,
    output logic           o_valid,
    input  logic           i_stall,
    output vrot_pkg::t_out o_x_out,
    output vrot_pkg::t_out o_y_out
);
    import vrot_pkg::*;

`include "vector2_rotate_macros.svh"

    localparam int NCELL = cell_count(STAGES);
    localparam int W     = DATA_WIDTH + INT_W;
    localparam logic signed [W-1:0] HALF = W'(1) << (DATA_WIDTH - 1);

    logic                w_en;
    logic [NCELL:0]      w_v;
    logic signed [W-1:0] w_x [0:NCELL];
    logic signed [W-1:0] w_y [0:NCELL];
    t_z                  w_z [0:NCELL];
    logic signed [W-1:0] w_rx, w_ry;
    logic                r_out_valid;
    t_out                r_x_out, r_y_out;

    // Freeze every stage while the output holds a stalled result
    assign w_en    = ~(r_out_valid & i_stall);
    assign o_stall = r_out_valid & i_stall;

    vrot_prescale #(
        .STAGES     (STAGES),
        .DATA_WIDTH (DATA_WIDTH),
        .W          (W)
    ) u_prescale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_x_in  (i_x_in),
        .i_y_in  (i_y_in),
        .i_angle (i_angle),
        .o_valid (w_v[0]),
        .o_x     (w_x[0]),
        .o_y     (w_y[0]),
        .o_z     (w_z[0])
    );

    // Chain of micro-rotation cells
    generate
        for (genvar gi = 0; gi < NCELL; gi++) begin : g_cell
            vrot_cell #(
                .W   (W),
                .IDX (gi)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_valid (w_v[gi]),
                .i_x     (w_x[gi]),
                .i_y     (w_y[gi]),
                .i_z     (w_z[gi]),
                .o_valid (w_v[gi+1]),
                .o_x     (w_x[gi+1]),
                .o_y     (w_y[gi+1]),
                .o_z     (w_z[gi+1])
            );
        end
    endgenerate

    // Round to nearest, ties toward plus infinity
    assign w_rx = w_x[NCELL] + HALF;
    assign w_ry = w_y[NCELL] + HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_v[NCELL];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x_out <= w_rx[DATA_WIDTH +: OUT_W];
            r_y_out <= w_ry[DATA_WIDTH +: OUT_W];
        end
    end

    assign o_valid = r_out_valid;
    assign o_x_out = r_x_out;
    assign o_y_out = r_y_out;

    // Checks
    `VROT_ASSERT_NXT(a_frozen_cells, i_rst_n, r_out_valid && i_stall, $stable(w_v[NCELL:1]), "cell valids moved while stalled")
    `VROT_ASSERT_IMP(a_out_source, i_rst_n, $rose(r_out_valid), $past(w_v[NCELL]), "result without a transaction in the last cell")
    `VROT_ASSERT_RST(a_reset_clear, !i_rst_n, !r_out_valid && (w_v == '0), "pipeline valid after reset")

endmodule
